[hw/rtl/ipv6cs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6cs_pkg
// Widths, constants and the end-around-carry add for the IPv6 checksum block.
// ----------------------------------------------------------------------------
package ipv6cs_pkg;

	localparam int unsigned WORD_W  = 16;
	localparam int unsigned NH_W    = 8;
	localparam int unsigned SUM_W   = WORD_W + 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [NH_W-1:0]   nh_t;
	typedef logic [SUM_W-1:0]  wide_t;

	typedef enum logic {
		OP_ADDR    = 1'b0,
		OP_PAYLOAD = 1'b1
	} op_t;

	localparam word_t BYTE_CNT_MAX  = '1;
	localparam word_t ODD_BYTE_MASK = word_t'(16'hFF00);

	// one's-complement add, carry folded back once (enough for two operands)
	function automatic word_t oc_add(input word_t a, input word_t b);
		logic [WORD_W:0] s;
		logic [WORD_W:0] f;
		begin
			s = {1'b0, a} + {1'b0, b};
			f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
			return f[WORD_W-1:0];
		end
	endfunction

	// fold a sum of up to four words to 16 bits, end-around carry fully applied
	function automatic word_t fold_wide(input wide_t t);
		logic [WORD_W:0] f;
		logic [WORD_W:0] g;
		begin
			f = {1'b0, t[WORD_W-1:0]} + {{(WORD_W-1){1'b0}}, t[SUM_W-1:WORD_W]};
			g = {1'b0, f[WORD_W-1:0]} + {{WORD_W{1'b0}}, f[WORD_W]};
			return g[WORD_W-1:0];
		end
	endfunction

endpackage

[hw/rtl/ipv6_pseudo_header_checksum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_pseudo_header_checksum
// IPv6 upper-layer checksum: sums pseudo-header address words and payload
// words, counts payload bytes, and on the last request emits the complement
// of the folded sum plus byte count and next header.
// A last request passes through the input register, then the result register,
//   before its checksum appears on the output.
// Throughput: one request per cycle unless a last request waits on out_stall.
// Reset: arst_n clears running sum, byte count and all valid flags at once.
// ----------------------------------------------------------------------------
module ipv6_pseudo_header_checksum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [ipv6cs_pkg::WORD_W-1:0]  data,
	input  logic                           odd_byte,
	input  logic [ipv6cs_pkg::NH_W-1:0]    next_header,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ipv6cs_pkg::WORD_W-1:0]  checksum
);

	// input register
	logic                    valid_s1;
	ipv6cs_pkg::op_t         op_s1;
	ipv6cs_pkg::word_t       data_s1;
	logic                    odd_s1;
	ipv6cs_pkg::nh_t         nh_s1;
	logic                    last_s1;

	// accumulator state
	ipv6cs_pkg::word_t       sum_q;
	ipv6cs_pkg::word_t       bytes_q;

	// result register
	logic                    out_valid_q;
	ipv6cs_pkg::word_t       checksum_q;

	logic                    out_free;
	logic                    adv_s1;
	logic                    in_acc;
	logic                    is_payload;
	ipv6cs_pkg::word_t       data_m;
	logic [ipv6cs_pkg::WORD_W:0] bytes_sum;
	ipv6cs_pkg::word_t       bytes_nx;
	ipv6cs_pkg::word_t       sum_nx;
	ipv6cs_pkg::wide_t       total;
	ipv6cs_pkg::word_t       final_sum;

	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	assign is_payload = (op_s1 == ipv6cs_pkg::OP_PAYLOAD);

	always_comb begin
		data_m    = data_s1;
		bytes_sum = {1'b0, bytes_q};
		if (is_payload) begin
			if (odd_s1) begin
				data_m    = data_s1 & ipv6cs_pkg::ODD_BYTE_MASK;
				bytes_sum = {1'b0, bytes_q} + (ipv6cs_pkg::WORD_W+1)'(1);
			end else begin
				bytes_sum = {1'b0, bytes_q} + (ipv6cs_pkg::WORD_W+1)'(2);
			end
		end
		bytes_nx = bytes_sum[ipv6cs_pkg::WORD_W] ? ipv6cs_pkg::BYTE_CNT_MAX
		                                         : bytes_sum[ipv6cs_pkg::WORD_W-1:0];
		sum_nx   = ipv6cs_pkg::oc_add(sum_q, data_m);
		total    = ipv6cs_pkg::SUM_W'(sum_q) + ipv6cs_pkg::SUM_W'(data_m)
		         + ipv6cs_pkg::SUM_W'(bytes_nx) + ipv6cs_pkg::SUM_W'(nh_s1);
		final_sum = ipv6cs_pkg::fold_wide(total);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= ipv6cs_pkg::op_t'(op);
			data_s1 <= data;
			odd_s1  <= odd_byte;
			nh_s1   <= next_header;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			bytes_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				sum_q   <= '0;
				bytes_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				bytes_q <= bytes_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			checksum_q <= ~final_sum;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> out_valid_q)
		else $error("last request did not produce a checksum");

	a_last_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (sum_q == '0 && bytes_q == '0))
		else $error("accumulator not cleared after last request");

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(checksum_q)))
		else $error("stalled checksum changed");

endmodule
